[sv/edge_mass_matrix_triplets_unit_defines.svh]
// Assertion macros for the edge mass-matrix triplet unit.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef EDGE_MASS_MATRIX_TRIPLETS_UNIT_DEFINES_SVH
`define EDGE_MASS_MATRIX_TRIPLETS_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, reset masks the check.
`define EMMT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, reset masks the check.
`define EMMT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define EMMT_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define EMMT_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[sv/emmt_pkg.sv]
// Shared constants and types for the edge mass-matrix triplet unit.
// No dependencies; used by the top level.
`timescale 1ns / 1ps
`default_nettype none

package emmt_pkg;

  // Field widths of the stream payloads
  localparam int NODE_W     = 10;
  localparam int IDX_W      = 11;
  localparam int COORD_W    = 32;
  localparam int VALUE_W    = 32;
  localparam int NODE_EXT_W = 17;

  // Packed stream widths, padded to whole bytes
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 56;

  // Defaults for the top-level parameters
  localparam int NODE_COUNT_DEF = 1024;
  localparam int COORD_BITS_DEF = 32;

  // Item kinds on the input tuser bit
  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EDGE = 1'b1
  } cmd_t;

endpackage

`default_nettype wire

[sv/emmt_ram.sv]
// Generic synchronous RAM: one write port, two registered read ports.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module emmt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read; read data holds while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

[sv/emmt_sqrt.sv]
// Pipelined integer square root, one root bit per stage, with a side tag.
// No dependencies; instantiated by the top level.
`timescale 1ns / 1ps
`default_nettype none

module emmt_sqrt #(
  parameter int ROOT_W = 34,
  parameter int TAG_W  = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [2*ROOT_W-1:0]   radicand,
  input  logic [TAG_W-1:0]      in_tag,
  output logic                  out_valid,
  output logic [ROOT_W-1:0]     root,
  output logic [TAG_W-1:0]      out_tag
);

  localparam int RAD_W = 2 * ROOT_W;

  logic [ROOT_W-1:0] valid_q;
  logic [RAD_W-1:0]  op_q  [ROOT_W-1];
  logic [RAD_W-1:0]  res_q [ROOT_W];
  logic [TAG_W-1:0]  tag_q [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    localparam int SH = 2 * (ROOT_W - 1 - i);
    localparam logic [RAD_W-1:0] ONE = {{(RAD_W-1){1'b0}}, 1'b1} << SH;

    logic             valid_p;
    logic [RAD_W-1:0] op_p;
    logic [RAD_W-1:0] res_p;
    logic [TAG_W-1:0] tag_p;
    logic [RAD_W-1:0] trial;
    logic             take;

    // Select the stage input
    if (i == 0) begin : g_first
      assign valid_p = in_valid;
      assign op_p    = radicand;
      assign res_p   = '0;
      assign tag_p   = in_tag;
    end else begin : g_next
      assign valid_p = valid_q[i-1];
      assign op_p    = op_q[i-1];
      assign res_p   = res_q[i-1];
      assign tag_p   = tag_q[i-1];
    end

    // Decide one root bit
    assign trial = res_p + ONE;
    assign take  = (op_p >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[i] <= 1'b0;
      end else if (en) begin
        valid_q[i] <= valid_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        res_q[i] <= take ? ((res_p >> 1) + ONE) : (res_p >> 1);
        tag_q[i] <= tag_p;
      end
    end

    // The last stage needs no remainder
    if (i < ROOT_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          op_q[i] <= take ? (op_p - trial) : op_p;
        end
      end
    end
  end

  assign out_valid = valid_q[ROOT_W-1];
  assign root      = res_q[ROOT_W-1][ROOT_W-1:0];
  assign out_tag   = tag_q[ROOT_W-1];

endmodule

`default_nettype wire

[sv/edge_mass_matrix_triplets_unit.sv]
// Top level: node coordinate store, edge length pipeline, triplet output.
// Depends on emmt_pkg, emmt_ram, emmt_sqrt and the assertion macro header.
//
//  channel  dir  handshake                    payload
//  s_axis   in   s_axis_tvalid/s_axis_tready  tdata: node_a, node_b, coord_x, coord_y
//                                             tuser: cmd
//  m_axis   out  m_axis_tvalid/m_axis_tready  tdata: row_index, col_index, entry_value
//                                             tlast: last
//
// Load items write the node store and yield no triplets; an edge item yields four triplets,
// one per cycle while m_axis_tready is high, so the single output channel sets the edge rate.
// Path of an edge from its accept to its first triplet: store read, difference, square,
// one stage per root bit, one stage per byte of the divide by three, output register.
// When the output stalls with the pipeline tail full, the whole pipeline and the input hold.
// Reset clears only valid bits and the output sequencer; the node store is not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "edge_mass_matrix_triplets_unit_defines.svh"

module edge_mass_matrix_triplets_unit #(
  parameter int NODE_COUNT = emmt_pkg::NODE_COUNT_DEF,
  parameter int COORD_BITS = emmt_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // node_a [9:0], node_b [19:10], coord_x [51:20], coord_y [83:52], zero pad
  input  logic [emmt_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // cmd [0]
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // row_index [10:0], col_index [21:11], entry_value [53:22], zero pad
  output logic [emmt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                               m_axis_tlast
);

  localparam int NODE_W     = emmt_pkg::NODE_W;
  localparam int IDX_W      = emmt_pkg::IDX_W;
  localparam int COORD_W    = emmt_pkg::COORD_W;
  localparam int VALUE_W    = emmt_pkg::VALUE_W;
  localparam int NODE_EXT_W = emmt_pkg::NODE_EXT_W;
  localparam int ADDR_W     = $clog2(NODE_COUNT);
  localparam int CW         = COORD_BITS;
  localparam int DIFF_W     = CW + 1;
  localparam int SQ_W       = 2 * DIFF_W;
  localparam int ROOT_W     = CW + 2;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int DIGIT_W    = 8;
  localparam int DIV_STAGES = (ROOT_W + DIGIT_W - 1) / DIGIT_W;
  localparam int DIV_W      = DIV_STAGES * DIGIT_W;
  localparam int TAG_W      = 2 * NODE_W;
  localparam logic [1:0] LAST_CNT = 2'd3;
  localparam logic [2:0] DIVISOR  = 3'd3;

  // Long division of one byte by three, carrying a remainder below three
  function automatic logic [DIGIT_W+1:0] div3_byte(input logic [1:0] rem_in,
                                                   input logic [DIGIT_W-1:0] bits);
    logic [2:0]         t;
    logic [1:0]         r;
    logic [DIGIT_W-1:0] q;
    r = rem_in;
    q = '0;
    for (int j = DIGIT_W - 1; j >= 0; j--) begin
      t = {r, bits[j]};
      if (t >= DIVISOR) begin
        q[j] = 1'b1;
        r    = 2'(t - DIVISOR);
      end else begin
        r = t[1:0];
      end
    end
    return {q, r};
  endfunction

  // Input unpack
  emmt_pkg::cmd_t        cmd;
  logic [NODE_W-1:0]     node_a;
  logic [NODE_W-1:0]     node_b;
  logic [COORD_W-1:0]    coord_x;
  logic [COORD_W-1:0]    coord_y;
  logic [NODE_EXT_W-1:0] na_ext;
  logic [NODE_EXT_W-1:0] nb_ext;
  logic                  na_ok;
  logic                  nb_ok;
  logic                  in_acc;
  logic                  adv;

  assign cmd     = emmt_pkg::cmd_t'(s_axis_tuser);
  assign node_a  = s_axis_tdata[NODE_W-1:0];
  assign node_b  = s_axis_tdata[2*NODE_W-1:NODE_W];
  assign coord_x = s_axis_tdata[2*NODE_W +: COORD_W];
  assign coord_y = s_axis_tdata[2*NODE_W+COORD_W +: COORD_W];
  assign na_ext  = NODE_EXT_W'(node_a);
  assign nb_ext  = NODE_EXT_W'(node_b);
  assign na_ok   = (na_ext < NODE_EXT_W'(NODE_COUNT));
  assign nb_ok   = (nb_ext < NODE_EXT_W'(NODE_COUNT));
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = adv;

  // Node store: {y, x} per node, both read ports used by edges
  logic [2*CW-1:0] rd_a;
  logic [2*CW-1:0] rd_b;

  emmt_ram #(
    .WIDTH (2 * CW),
    .DEPTH (NODE_COUNT)
  ) u_store (
    .clk     (clk),
    .we      (in_acc && (cmd == emmt_pkg::CMD_LOAD) && na_ok),
    .waddr   (na_ext[ADDR_W-1:0]),
    .wdata   ({coord_y[CW-1:0], coord_x[CW-1:0]}),
    .re      (adv),
    .raddr_a (na_ext[ADDR_W-1:0]),
    .raddr_b (nb_ext[ADDR_W-1:0]),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // Stage 1: store read in flight
  logic             p1_valid;
  logic [TAG_W-1:0] p1_tag;
  logic             p1_a_ok;
  logic             p1_b_ok;

  // Stage 2: absolute differences
  logic              p2_valid;
  logic [TAG_W-1:0]  p2_tag;
  logic [DIFF_W-1:0] p2_dx;
  logic [DIFF_W-1:0] p2_dy;

  // Stage 3: squares
  logic             p3_valid;
  logic [TAG_W-1:0] p3_tag;
  logic [SQ_W-1:0]  p3_sx;
  logic [SQ_W-1:0]  p3_sy;

  // Out-of-range nodes read as the origin
  logic [CW-1:0]            xa_raw, ya_raw, xb_raw, yb_raw;
  logic signed [DIFF_W-1:0] dx_s, dy_s;
  logic [DIFF_W-1:0]        dx_abs, dy_abs;

  assign xa_raw = p1_a_ok ? rd_a[CW-1:0]    : '0;
  assign ya_raw = p1_a_ok ? rd_a[2*CW-1:CW] : '0;
  assign xb_raw = p1_b_ok ? rd_b[CW-1:0]    : '0;
  assign yb_raw = p1_b_ok ? rd_b[2*CW-1:CW] : '0;
  assign dx_s   = $signed({xa_raw[CW-1], xa_raw}) - $signed({xb_raw[CW-1], xb_raw});
  assign dy_s   = $signed({ya_raw[CW-1], ya_raw}) - $signed({yb_raw[CW-1], yb_raw});
  assign dx_abs = dx_s[DIFF_W-1] ? DIFF_W'(-dx_s) : DIFF_W'(dx_s);
  assign dy_abs = dy_s[DIFF_W-1] ? DIFF_W'(-dy_s) : DIFF_W'(dy_s);

  // Front pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
    end else if (adv) begin
      p1_valid <= in_acc && (cmd == emmt_pkg::CMD_EDGE);
      p2_valid <= p1_valid;
      p3_valid <= p2_valid;
    end
  end

  // Front pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      p1_tag  <= {node_b, node_a};
      p1_a_ok <= na_ok;
      p1_b_ok <= nb_ok;
      p2_tag  <= p1_tag;
      p2_dx   <= dx_abs;
      p2_dy   <= dy_abs;
      p3_tag  <= p2_tag;
      p3_sx   <= SQ_W'(p2_dx) * SQ_W'(p2_dx);
      p3_sy   <= SQ_W'(p2_dy) * SQ_W'(p2_dy);
    end
  end

  // Square root of dx^2 + dy^2
  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  logic [TAG_W-1:0]  sq_tag;

  emmt_sqrt #(
    .ROOT_W (ROOT_W),
    .TAG_W  (TAG_W)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (p3_valid),
    .radicand  (RAD_W'(p3_sx) + RAD_W'(p3_sy)),
    .in_tag    (p3_tag),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_tag   (sq_tag)
  );

  // Divide the length by three, one byte per stage
  logic [DIV_STAGES-1:0] dv_valid;
  logic [DIV_W-1:0]      dv_quo [DIV_STAGES];
  logic [TAG_W-1:0]      dv_tag [DIV_STAGES];
  logic [DIV_W-1:0]      dv_num [DIV_STAGES-1];
  logic [1:0]            dv_rem [DIV_STAGES-1];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    logic               valid_p;
    logic [DIV_W-1:0]   num_p;
    logic [DIV_W-1:0]   quo_p;
    logic [1:0]         rem_p;
    logic [TAG_W-1:0]   tag_p;
    logic [DIGIT_W+1:0] step;

    if (s == 0) begin : g_first
      assign valid_p = sq_valid;
      assign num_p   = DIV_W'(sq_root);
      assign quo_p   = '0;
      assign rem_p   = '0;
      assign tag_p   = sq_tag;
    end else begin : g_next
      assign valid_p = dv_valid[s-1];
      assign num_p   = dv_num[s-1];
      assign quo_p   = dv_quo[s-1];
      assign rem_p   = dv_rem[s-1];
      assign tag_p   = dv_tag[s-1];
    end

    assign step = div3_byte(rem_p, num_p[DIV_W-1 -: DIGIT_W]);

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[s] <= 1'b0;
      end else if (adv) begin
        dv_valid[s] <= valid_p;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_quo[s] <= {quo_p[DIV_W-DIGIT_W-1:0], step[DIGIT_W+1:2]};
        dv_tag[s] <= tag_p;
      end
    end

    // The last stage drops the leftover digits and remainder
    if (s < DIV_STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv) begin
          dv_num[s] <= num_p << DIGIT_W;
          dv_rem[s] <= step[1:0];
        end
      end
    end
  end

  logic             dl_valid;
  logic [DIV_W-1:0] dl_quo;
  logic [TAG_W-1:0] dl_tag;

  assign dl_valid = dv_valid[DIV_STAGES-1];
  assign dl_quo   = dv_quo[DIV_STAGES-1];
  assign dl_tag   = dv_tag[DIV_STAGES-1];

  // Output sequencer: holds one edge and walks its four triplets
  logic               ser_valid;
  logic [1:0]         ser_cnt;
  logic [NODE_W-1:0]  ser_na;
  logic [NODE_W-1:0]  ser_nb;
  logic [VALUE_W-1:0] ser_diag;
  logic [VALUE_W-1:0] ser_off;
  logic               ser_free;
  logic               out_acc;

  assign out_acc  = m_axis_tvalid && m_axis_tready;
  assign ser_free = !ser_valid || (m_axis_tready && (ser_cnt == LAST_CNT));
  assign adv      = !dl_valid || ser_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_valid <= 1'b0;
      ser_cnt   <= '0;
    end else if (dl_valid && ser_free) begin
      ser_valid <= 1'b1;
      ser_cnt   <= '0;
    end else if (out_acc) begin
      if (ser_cnt == LAST_CNT) begin
        ser_valid <= 1'b0;
      end
      ser_cnt <= ser_cnt + 2'd1;
    end
  end

  // L/6 is half of L/3, both truncated
  always_ff @(posedge clk) begin
    if (dl_valid && ser_free) begin
      ser_na   <= dl_tag[NODE_W-1:0];
      ser_nb   <= dl_tag[TAG_W-1:NODE_W];
      ser_diag <= VALUE_W'(dl_quo);
      ser_off  <= VALUE_W'(dl_quo >> 1);
    end
  end

  // Triplet order (a,a), (a,b), (b,a), (b,b)
  logic [NODE_W-1:0]  row_node;
  logic [NODE_W-1:0]  col_node;
  logic [IDX_W-1:0]   row_index;
  logic [IDX_W-1:0]   col_index;
  logic [VALUE_W-1:0] entry_value;

  assign row_node    = ser_cnt[1] ? ser_nb : ser_na;
  assign col_node    = ser_cnt[0] ? ser_nb : ser_na;
  assign row_index   = IDX_W'(row_node) + IDX_W'(1);
  assign col_index   = IDX_W'(col_node) + IDX_W'(1);
  assign entry_value = (ser_cnt[1] == ser_cnt[0]) ? ser_diag : ser_off;

  assign m_axis_tvalid = ser_valid;
  assign m_axis_tlast  = (ser_cnt == LAST_CNT);
  assign m_axis_tdata  = emmt_pkg::OUT_TDATA_W'({entry_value, col_index, row_index});

  // Checks
  `EMMT_ASSERT_NXT(a_edge_enters, clk, rst, in_acc && (cmd == emmt_pkg::CMD_EDGE), p1_valid, "accepted edge did not enter the pipeline")
  `EMMT_ASSERT_NXT(a_load_silent, clk, rst, in_acc && (cmd == emmt_pkg::CMD_LOAD), !p1_valid, "load item entered the edge pipeline")
  `EMMT_ASSERT_NXT(a_run_unbroken, clk, rst, out_acc && !m_axis_tlast, m_axis_tvalid, "triplet run of an edge broke off")
  `EMMT_ASSERT_NXT(a_tail_holds, clk, rst, dl_valid && !adv, dl_valid && $stable(dl_tag), "stalled pipeline tail lost its edge")

endmodule

`default_nettype wire

[test/tb_edge_mass_matrix_triplets_unit.sv]
`timescale 1ns / 1ps
// Testbench for edge_mass_matrix_triplets_unit: loads node coordinates, sends edges and checks
// every triplet against a coordinate table and an edge length calculation of its own.
// Depends on emmt_pkg and the unit's RTL.

module tb_edge_mass_matrix_triplets_unit;

  localparam int SETTLE_CYCLES = 60;

  typedef struct {
    emmt_pkg::cmd_t cmd;
    logic [9:0]     node_a;
    logic [9:0]     node_b;
    logic [31:0]    coord_x;
    logic [31:0]    coord_y;
    bit             drain;
    int             gap;
  } node_item_t;

  typedef struct {
    logic [10:0] row;
    logic [10:0] col;
    logic [31:0] value;
    logic        last;
  } triplet_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [emmt_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                             s_axis_tuser = 1'b0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [emmt_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                             m_axis_tlast;

  // Coordinate table as the unit should hold it
  logic [31:0] x_tab [emmt_pkg::NODE_COUNT_DEF];
  logic [31:0] y_tab [emmt_pkg::NODE_COUNT_DEF];

  node_item_t pending_items[$];
  triplet_t   triplet_q[$];

  // Nodes already loaded by the stimulus, so edges only touch written entries
  bit         stim_written [emmt_pkg::NODE_COUNT_DEF];
  int         stim_nodes[$];

  bit in_taken  = 1'b0;
  bit out_taken = 1'b0;
  bit tx_calm   = 1'b0;
  bit rx_calm   = 1'b0;
  int tx_count  = 0;
  int rx_count  = 0;
  int rx_stall  = 0;
  int errors    = 0;

  edge_mass_matrix_triplets_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t ERROR %s: got %0h, wanted %0h", $time, what, got, want);
    errors++;
  endtask

  // Euclidean length of a-b in unsigned Q18.16, floor of the integer root of dx^2 + dy^2
  function automatic logic [33:0] edge_length_q16(logic [31:0] xa, logic [31:0] ya,
                                                  logic [31:0] xb, logic [31:0] yb);
    logic [33:0] dx;
    logic [33:0] dy;
    logic [67:0] sum;
    logic [67:0] sq;
    logic [33:0] root;
    logic [33:0] trial;
    dx = {{2{xa[31]}}, xa} - {{2{xb[31]}}, xb};
    dy = {{2{ya[31]}}, ya} - {{2{yb[31]}}, yb};
    if (dx[33]) dx = -dx;
    if (dy[33]) dy = -dy;
    sum  = 68'(dx) * 68'(dx) + 68'(dy) * 68'(dy);
    root = '0;
    for (int b = 33; b >= 0; b--) begin
      trial = root | (34'd1 << b);
      sq    = 68'(trial) * 68'(trial);
      if (sq <= sum) root = trial;
    end
    return root;
  endfunction

  // Update the table on a load, queue the four triplets of an edge
  task automatic predict_triplets(emmt_pkg::cmd_t cmd, logic [emmt_pkg::IN_TDATA_W-1:0] data);
    logic [9:0]  na;
    logic [9:0]  nb;
    logic [33:0] len;
    logic [10:0] idx [2];
    triplet_t    t;
    na = data[9:0];
    nb = data[19:10];
    if (cmd == emmt_pkg::CMD_LOAD) begin
      x_tab[na] = data[51:20];
      y_tab[na] = data[83:52];
    end else begin
      len    = edge_length_q16(x_tab[na], y_tab[na], x_tab[nb], y_tab[nb]);
      idx[0] = 11'(na) + 11'd1;
      idx[1] = 11'(nb) + 11'd1;
      for (int j = 0; j < 2; j++) begin
        for (int k = 0; k < 2; k++) begin
          t.row   = idx[j];
          t.col   = idx[k];
          t.value = (j == k) ? 32'(len / 34'd3) : 32'(len / 34'd6);
          t.last  = (j == 1 && k == 1);
          triplet_q.push_back(t);
        end
      end
    end
  endtask

  task automatic add_item(emmt_pkg::cmd_t cmd, int a, int b, logic [31:0] x, logic [31:0] y,
                          bit drain);
    node_item_t it;
    // switch between idle-free stretches and random gaps
    if (tx_count % 20 == 0) tx_calm = ($urandom_range(0, 3) == 0);
    tx_count++;
    it.cmd     = cmd;
    it.node_a  = 10'(a);
    it.node_b  = 10'(b);
    it.coord_x = x;
    it.coord_y = y;
    it.drain   = drain;
    it.gap     = tx_calm ? 0 : $urandom_range(0, 15);
    pending_items.push_back(it);
    if (cmd == emmt_pkg::CMD_LOAD && !stim_written[a]) begin
      stim_written[a] = 1'b1;
      stim_nodes.push_back(a);
    end
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return 32'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_node();
    return stim_nodes[$urandom_range(0, stim_nodes.size() - 1)];
  endfunction

  // Driver: present the next item after its gap, hold it until taken
  always @(negedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && !in_taken) begin
        // hold the item
      end else if (pending_items.size() == 0 ||
                   (pending_items[0].drain && triplet_q.size() != 0)) begin
        s_axis_tvalid <= 1'b0;
      end else if (pending_items[0].gap != 0) begin
        s_axis_tvalid <= 1'b0;
        pending_items[0].gap = pending_items[0].gap - 1;
      end else begin
        s_axis_tdata  <= {4'b0, pending_items[0].coord_y, pending_items[0].coord_x,
                          pending_items[0].node_b, pending_items[0].node_a};
        s_axis_tuser  <= pending_items[0].cmd;
        s_axis_tvalid <= 1'b1;
        void'(pending_items.pop_front());
      end
    end
  end

  // Receiver: stall a random number of cycles after each accepted triplet
  always @(negedge clk) begin
    if (!rst) begin
      if (out_taken) begin
        rx_count++;
        if (rx_count % 16 == 0) rx_calm = ($urandom_range(0, 3) == 0);
        rx_stall = rx_calm ? 0 : $urandom_range(0, 15);
      end
      if (rx_stall > 0) begin
        m_axis_tready <= 1'b0;
        rx_stall--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Monitor: check accepted triplets, predict from accepted items
  always @(posedge clk) begin
    triplet_t got;
    triplet_t want;
    in_taken  <= !rst && s_axis_tvalid && s_axis_tready;
    out_taken <= !rst && m_axis_tvalid && m_axis_tready;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.row   = m_axis_tdata[10:0];
      got.col   = m_axis_tdata[21:11];
      got.value = m_axis_tdata[53:22];
      got.last  = m_axis_tlast;
      if (triplet_q.size() == 0) begin
        report("unexpected triplet", 64'({got.row, got.col, got.value}), '0);
      end else begin
        want = triplet_q.pop_front();
        if (got.row !== want.row) report("row_index", 64'(got.row), 64'(want.row));
        if (got.col !== want.col) report("col_index", 64'(got.col), 64'(want.col));
        if (got.value !== want.value) begin
          report("entry_value", 64'(got.value), 64'(want.value));
        end
        if (got.last !== want.last) report("last", 64'(got.last), 64'(want.last));
      end
    end
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      predict_triplets(emmt_pkg::cmd_t'(s_axis_tuser), s_axis_tdata);
    end
  end

  initial begin
    int a;
    int b;
    int wait_limit;

    // Directed: extreme coordinates, reversed and degenerate edges, coincident nodes
    add_item(emmt_pkg::CMD_LOAD, 0, 1023, 32'h8000_0000, 32'h8000_0000, 1'b0);
    add_item(emmt_pkg::CMD_LOAD, 1023, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    add_item(emmt_pkg::CMD_EDGE, 0, 1023, 32'hFFFF_FFFF, 32'h0, 1'b0);
    add_item(emmt_pkg::CMD_EDGE, 1023, 0, 32'h0, 32'hFFFF_FFFF, 1'b0);
    add_item(emmt_pkg::CMD_EDGE, 0, 0, 32'h0, 32'h0, 1'b0);
    add_item(emmt_pkg::CMD_EDGE, 1023, 1023, 32'h0, 32'h0, 1'b0);
    add_item(emmt_pkg::CMD_LOAD, 5, 10'h2AA, 32'h0, 32'h0, 1'b0);
    add_item(emmt_pkg::CMD_LOAD, 6, 10'h155, 32'h0, 32'h0, 1'b0);
    add_item(emmt_pkg::CMD_EDGE, 5, 6, 32'h0, 32'h0, 1'b0);
    add_item(emmt_pkg::CMD_LOAD, 7, 3, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    add_item(emmt_pkg::CMD_EDGE, 7, 0, 32'h0, 32'h0, 1'b0);
    add_item(emmt_pkg::CMD_EDGE, 5, 7, 32'h0, 32'h0, 1'b0);
    add_item(emmt_pkg::CMD_LOAD, 512, 511, 32'h0003_0000, 32'h0004_0000, 1'b0);
    add_item(emmt_pkg::CMD_EDGE, 5, 512, 32'h0, 32'h0, 1'b0);
    add_item(emmt_pkg::CMD_EDGE, 512, 5, 32'h0, 32'h0, 1'b0);
    add_item(emmt_pkg::CMD_LOAD, 0, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    add_item(emmt_pkg::CMD_EDGE, 0, 5, 32'h0, 32'h0, 1'b0);
    add_item(emmt_pkg::CMD_EDGE, 5, 1023, 32'h0, 32'h0, 1'b0);
    add_item(emmt_pkg::CMD_LOAD, 341, 682, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    add_item(emmt_pkg::CMD_EDGE, 341, 1023, 32'h0, 32'h0, 1'b0);
    add_item(emmt_pkg::CMD_EDGE, 341, 0, 32'h0, 32'h0, 1'b0);

    // Random: mostly edges between loaded nodes, with reloads and fresh loads mixed in
    for (int n = 0; n < 250; n++) begin
      if (stim_nodes.size() < 2 || $urandom_range(0, 99) < 35) begin
        a = $urandom_range(0, 1) ? int'($urandom_range(0, 1023)) : pick_node();
        add_item(emmt_pkg::CMD_LOAD, a, $urandom_range(0, 1023), rand_coord(), rand_coord(),
                 n == 120);
      end else begin
        a = pick_node();
        b = ($urandom_range(0, 9) == 0) ? a : pick_node();
        add_item(emmt_pkg::CMD_EDGE, a, b, $urandom, $urandom,
                 n == 120 || $urandom_range(0, 49) == 0);
      end
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for all items to go in, then for the last triplets
    while (pending_items.size() != 0 || s_axis_tvalid) @(negedge clk);
    wait_limit = 200 + 20 * triplet_q.size();
    while (triplet_q.size() != 0 && wait_limit > 0) begin
      @(negedge clk);
      wait_limit--;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (triplet_q.size() != 0) begin
      report("triplets never delivered", 64'(triplet_q.size()), '0);
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Run limit, far above the slowest legal run
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/emmt_pkg.sv
sv/emmt_ram.sv
sv/emmt_sqrt.sv
sv/edge_mass_matrix_triplets_unit.sv
test/tb_edge_mass_matrix_triplets_unit.sv
